### hdl/bpra_pkg.sv
// Package for the bitmap page-run allocator: sizes, command and status codes,
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
package bpra_pkg;
  localparam int PoolPages = 65536;
  localparam int PageShift = 12;
  localparam int IdxW = 16;
  localparam int WordW = 32;
  localparam int WordIdxW = IdxW - 5;
  localparam logic [63:0] AlignMask = 64'h1F_FFFF;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;
  localparam logic [1:0] ST_FREE_BAD = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_TEST, S_MARK_RD, S_MARK_WR,
    S_ADDR, S_DONE
  } state_t;
endpackage

### hdl/bitmap_page_run_allocator.sv
// Top level of the bitmap page-run allocator: APB register, bitmap memory
// (2048 words of 32 bits) and the sequencer. Uses bpra_pkg.
// Allocate reads and tests each page in turn, then reads and writes each page of the
// found run to mark it; free reads and writes each page of its run to clear it.
// One request at a time; ready is low while a request is in work.
// After reset a clearing pass zeroes all 2048 bitmap words before the
// first request is taken; configuration writes are taken throughout.
`timescale 1ns / 1ps
module bitmap_page_run_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [16:0] page_count,
  input  logic [63:0] address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] run_address
);
  bpra_pkg::state_t state, state_next;
  logic [63:0] image_end;
  logic [31:0] mem [2048];
  logic [31:0] rd_word;
  logic [10:0] clr_addr;
  logic        cmd_r;
  logic [16:0] cnt_r;
  logic [63:0] addr_r;
  logic [16:0] pos;     // current page being examined or written
  logic [16:0] lim;     // exclusive upper bound of the scan
  logic        wrap;    // in second pass
  logic [16:0] run;
  logic [15:0] hint;
  logic [16:0] start;
  logic [16:0] mark_end;
  logic [63:0] base;
  logic [63:0] off;
  logic [35:0] idx_hi;
  logic        mem_we;
  logic [10:0] mem_waddr;
  logic [31:0] mem_wdata;

  assign pready = 1'b1;
  assign prdata = image_end;
  assign base = (image_end + bpra_pkg::AlignMask) & ~bpra_pkg::AlignMask;
  assign off = addr_r - base;
  // Page index bits above the pool size; nonzero means the address is past the pool.
  assign idx_hi = off[63:28];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_end <= '0;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      image_end <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_word <= mem[pos[15:5]];
  end

  always_comb begin
    state_next = state;
    case (state)
      bpra_pkg::S_CLEAR: if (clr_addr == 11'h7FF) state_next = bpra_pkg::S_IDLE;
      bpra_pkg::S_IDLE: if (in_valid) state_next = bpra_pkg::S_CHECK;
      bpra_pkg::S_CHECK: begin
        if (cmd_r == bpra_pkg::CMD_ALLOC) begin
          if (cnt_r == 17'd0 || cnt_r > 17'(bpra_pkg::PoolPages))
            state_next = bpra_pkg::S_DONE;
          else state_next = bpra_pkg::S_SCAN_RD;
        end else begin
          if (addr_r == 64'd0 || cnt_r == 17'd0 || addr_r < base || idx_hi != '0 ||
              {2'b0, off[27:12]} + {1'b0, cnt_r} > 18'(bpra_pkg::PoolPages))
            state_next = bpra_pkg::S_DONE;
          else state_next = bpra_pkg::S_MARK_RD;
        end
      end
      bpra_pkg::S_SCAN_RD: begin
        if (pos >= lim) begin
          if (wrap || hint == 16'd0) state_next = bpra_pkg::S_DONE;
          else state_next = bpra_pkg::S_SCAN_RD;
        end else state_next = bpra_pkg::S_SCAN_TEST;
      end
      bpra_pkg::S_SCAN_TEST: begin
        if (!rd_word[pos[4:0]] && run + 17'd1 == cnt_r) state_next = bpra_pkg::S_MARK_RD;
        else state_next = bpra_pkg::S_SCAN_RD;
      end
      bpra_pkg::S_MARK_RD: state_next = bpra_pkg::S_MARK_WR;
      bpra_pkg::S_MARK_WR: begin
        if (pos + 17'd1 == mark_end) state_next = bpra_pkg::S_ADDR;
        else state_next = bpra_pkg::S_MARK_RD;
      end
      bpra_pkg::S_ADDR: state_next = bpra_pkg::S_DONE;
      bpra_pkg::S_DONE: if (out_ready) state_next = bpra_pkg::S_IDLE;
      default: state_next = bpra_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == bpra_pkg::S_IDLE);
    out_valid = (state == bpra_pkg::S_DONE);
    mem_we = 1'b0;
    mem_waddr = pos[15:5];
    mem_wdata = rd_word;
    case (state)
      bpra_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      bpra_pkg::S_MARK_WR: begin
        mem_we = 1'b1;
        mem_wdata[pos[4:0]] = (cmd_r == bpra_pkg::CMD_ALLOC);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpra_pkg::S_CLEAR;
      clr_addr <= '0;
      hint <= '0;
    end else begin
      state <= state_next;
      if (state == bpra_pkg::S_CLEAR) clr_addr <= clr_addr + 11'd1;
      case (state)
        bpra_pkg::S_IDLE: if (in_valid) begin
          cmd_r <= command;
          cnt_r <= page_count;
          addr_r <= address;
        end
        bpra_pkg::S_CHECK: begin
          run <= '0;
          wrap <= 1'b0;
          status <= (cmd_r == bpra_pkg::CMD_ALLOC) ? bpra_pkg::ST_ALLOC_FAIL
                                                   : bpra_pkg::ST_FREE_BAD;
          run_address <= '0;
          if (cmd_r == bpra_pkg::CMD_ALLOC) begin
            pos <= {1'b0, hint};
            lim <= 17'(bpra_pkg::PoolPages);
          end else begin
            pos <= {1'b0, off[27:12]};
            start <= {1'b0, off[27:12]};
            mark_end <= {1'b0, off[27:12]} + cnt_r;
          end
        end
        bpra_pkg::S_SCAN_RD: if (pos >= lim && !wrap) begin
          wrap <= 1'b1;
          pos <= '0;
          lim <= {1'b0, hint};
          run <= '0;
        end
        bpra_pkg::S_SCAN_TEST: begin
          if (rd_word[pos[4:0]]) begin
            run <= '0;
            pos <= pos + 17'd1;
          end else if (run + 17'd1 == cnt_r) begin
            pos <= pos + 17'd1 - cnt_r;
            start <= pos + 17'd1 - cnt_r;
            mark_end <= pos + 17'd1;
          end else begin
            run <= run + 17'd1;
            pos <= pos + 17'd1;
          end
        end
        bpra_pkg::S_MARK_WR: pos <= pos + 17'd1;
        bpra_pkg::S_ADDR: begin
          if (cmd_r == bpra_pkg::CMD_ALLOC) begin
            status <= bpra_pkg::ST_ALLOCATED;
            run_address <= base + {35'd0, start, 12'd0};
            hint <= mark_end[15:0];
          end else begin
            status <= bpra_pkg::ST_FREED;
            if (start[15:0] < hint) hint <= start[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  a_one_hand: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("request and result sides active together");
  a_hint_after_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == bpra_pkg::S_ADDR && cmd_r == bpra_pkg::CMD_ALLOC) |=> hint == $past(mark_end[15:0]))
    else $error("hint not moved past run");
  a_mark_in_pool: assert property (@(posedge clk) disable iff (rst)
    state == bpra_pkg::S_MARK_WR |-> pos < 17'(bpra_pkg::PoolPages))
    else $error("mark outside pool");
endmodule
